// File: rtl/xmcr_pkg.sv
// Shared types and constants for the XMODEM checksum receiver.
// No dependencies; imported by every module of the block except xmcr_ram.
`default_nettype none

package xmcr_pkg;

  // Protocol characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_ALL = 8'hFF;

  // Packet geometry
  localparam int PACKET_BYTES = 128;
  localparam int WORD_COUNT   = PACKET_BYTES / 4;
  localparam int WORD_IDX_W   = $clog2(WORD_COUNT);
  localparam int BYTE_IDX_W   = $clog2(PACKET_BYTES);
  localparam logic [7:0] SUM_POS = 8'(PACKET_BYTES + 3);
  localparam logic [WORD_IDX_W-1:0] WORD_LAST = WORD_IDX_W'(WORD_COUNT - 1);

  // Register reset values and indexes
  localparam logic [31:0] LOAD_BASE_RESET = 32'h0000_8000;
  localparam logic [31:0] TIMEOUT_RESET   = 32'd4000000;
  localparam logic        REG_LOAD_BASE   = 1'b0;
  localparam logic        REG_TIMEOUT     = 1'b1;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [1:0] CMD_NAK   = 2'd0;
  localparam logic [1:0] CMD_EOT   = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  // Result kinds
  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
  } cmd_t;

  typedef struct packed {
    logic                  en;
    logic [1:0]            lane;
    logic [WORD_IDX_W-1:0] addr;
    logic [7:0]            data;
  } buf_wr_t;

  typedef struct packed {
    logic        en;
    logic        idx;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// File: rtl/xmodem_checksum_receiver.sv
// XMODEM receiver (8-bit checksum, 128-byte packets), top level.
// Depends on xmcr_pkg, xmcr_ram, xmcr_fifo, xmcr_front and xmcr_back.
//
// Items are pushed as timer ticks (cmd 0) or received bytes (cmd 1); results
// come out as transmit bytes (ACK/NAK) or 32-bit memory word writes, in
// order, with last set on the final result of each item. Ticks and header
// or data bytes leave full low unless the two-entry command queue is full.
// A good checksum byte raises full until the back has walked the packet
// buffer: 32 word writes at one per cycle while pop is held high (set by
// the single buffer read port, registered read) plus the ACK. A NAK or
// EOT ACK passes through the command queue and the result register after
// its item. After EOT is acknowledged every later item is accepted and
// dropped. Registers: load_base at 0x0 (also reloads the write address),
// timeout_ticks at 0x4; write them only while the block is idle.
`default_nettype none

module xmodem_checksum_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [7:0]  rx_byte,
  // results
  output logic             empty,
  input  wire logic        pop,
  output logic             out_kind,
  output logic [7:0]       tx_byte,
  output logic [31:0]      write_addr,
  output logic [31:0]      write_data,
  output logic             finished,
  output logic             last,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import xmcr_pkg::*;

  cfg_wr_t               cfg_wr;
  logic [31:0]           load_base;
  logic [31:0]           timeout_ticks;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_push;
  logic                  q_pop;
  cmd_t                  q_in;
  cmd_t                  q_head;
  buf_wr_t               buf_wr;
  logic [WORD_IDX_W-1:0] buf_raddr;
  logic [31:0]           buf_rdata;
  logic                  drain_done;

  // register port decode
  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[2];
  assign cfg_wr.data = pwdata;
  assign prdata      = (paddr[2] == REG_TIMEOUT) ? timeout_ticks : load_base;

  xmcr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .cmd           (cmd),
    .rx_byte       (rx_byte),
    .full          (full),
    .cfg_wr        (cfg_wr),
    .load_base     (load_base),
    .timeout_ticks (timeout_ticks),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in),
    .buf_wr        (buf_wr),
    .drain_done    (drain_done)
  );

  xmcr_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_cmd  (q_in),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_cmd  (q_head),
    .q_empty (q_empty)
  );

  // packet buffer: one byte lane per RAM, word index as address
  for (genvar lane = 0; lane < 4; lane++) begin : g_lane
    xmcr_ram #(
      .WIDTH (8),
      .DEPTH (WORD_COUNT)
    ) u_ram (
      .clk   (clk),
      .we    (buf_wr.en && (buf_wr.lane == 2'(lane))),
      .waddr (buf_wr.addr),
      .wdata (buf_wr.data),
      .raddr (buf_raddr),
      .rdata (buf_rdata[lane*8 +: 8])
    );
  end

  xmcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .buf_raddr  (buf_raddr),
    .buf_rdata  (buf_rdata),
    .drain_done (drain_done),
    .empty      (empty),
    .pop        (pop),
    .out_kind   (out_kind),
    .tx_byte    (tx_byte),
    .write_addr (write_addr),
    .write_data (write_data),
    .finished   (finished),
    .last       (last)
  );

endmodule

`default_nettype wire

// File: rtl/xmcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module xmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/xmcr_fifo.sv
// Short command queue between the front and the back of the receiver.
// Depends on xmcr_pkg.
`default_nettype none

module xmcr_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire xmcr_pkg::cmd_t wr_cmd,
  output logic               q_full,
  input  wire logic          rd,
  output xmcr_pkg::cmd_t     rd_cmd,
  output logic               q_empty
);
  import xmcr_pkg::*;

  cmd_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign q_full  = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign q_empty = (count == '0);
  assign rd_cmd  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full && !rd |-> !wr) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !rd) else $error("command queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_PTR_W + 1)'(Q_DEPTH)) else $error("command queue level out of range");

endmodule

`default_nettype wire

// File: rtl/xmcr_front.sv
// Front of the receiver: accepts items, parses packets, runs the timeout,
// fills the packet buffer and queues commands. Depends on xmcr_pkg.
`default_nettype none

module xmcr_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic               cmd,
  input  wire logic [7:0]         rx_byte,
  output logic                    full,
  input  wire xmcr_pkg::cfg_wr_t  cfg_wr,
  output logic [31:0]             load_base,
  output logic [31:0]             timeout_ticks,
  input  wire logic               q_full,
  output logic                    q_push,
  output xmcr_pkg::cmd_t          q_cmd,
  output xmcr_pkg::buf_wr_t       buf_wr,
  input  wire logic               drain_done
);
  import xmcr_pkg::*;

  logic [7:0]  packet_position, packet_position_next;
  logic [7:0]  expected_block, expected_block_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  received_block, received_block_next;
  logic [31:0] next_address, next_address_next;
  logic [31:0] idle_ticks, idle_ticks_next;
  logic        upload_done, upload_done_next;
  logic        drain_busy, drain_busy_next;
  logic [31:0] load_base_next;
  logic [31:0] timeout_ticks_next;

  logic        accept;
  logic [31:0] ticks_inc;
  logic [7:0]  sum_add;
  logic [7:0]  data_idx;

  assign full      = q_full || drain_busy;
  assign accept    = push && !full;
  assign ticks_inc = idle_ticks + 32'd1;
  assign sum_add   = running_sum + rx_byte;
  assign data_idx  = packet_position - 8'd3;

  // packet parser and timeout
  always_comb begin
    packet_position_next = packet_position;
    expected_block_next  = expected_block;
    running_sum_next     = running_sum;
    received_block_next  = received_block;
    next_address_next    = next_address;
    idle_ticks_next      = idle_ticks;
    upload_done_next     = upload_done;
    drain_busy_next      = drain_busy && !drain_done;
    load_base_next       = load_base;
    timeout_ticks_next   = timeout_ticks;
    q_push               = 1'b0;
    q_cmd.kind           = CMD_NAK;
    q_cmd.addr           = next_address;
    buf_wr.en            = 1'b0;
    buf_wr.lane          = data_idx[1:0];
    buf_wr.addr          = data_idx[BYTE_IDX_W-1:2];
    buf_wr.data          = rx_byte;

    if (accept && !upload_done) begin
      if (!cmd) begin
        // timer tick
        if (ticks_inc >= timeout_ticks) begin
          idle_ticks_next = '0;
          q_push          = 1'b1;
        end else begin
          idle_ticks_next = ticks_inc;
        end
      end else begin
        idle_ticks_next = '0;
        if (packet_position == 8'd0) begin
          if (rx_byte == CH_EOT) begin
            upload_done_next = 1'b1;
            q_push           = 1'b1;
            q_cmd.kind       = CMD_EOT;
          end else if (rx_byte == CH_SOH) begin
            running_sum_next     = rx_byte;
            packet_position_next = 8'd1;
          end else begin
            q_push = 1'b1;
          end
        end else if (packet_position == 8'd1) begin
          if (rx_byte == expected_block) begin
            received_block_next  = rx_byte;
            running_sum_next     = sum_add;
            packet_position_next = 8'd2;
          end else begin
            packet_position_next = 8'd0;
            q_push               = 1'b1;
          end
        end else if (packet_position == 8'd2) begin
          if (rx_byte == CH_ALL - received_block) begin
            running_sum_next     = sum_add;
            packet_position_next = 8'd3;
          end else begin
            packet_position_next = 8'd0;
            q_push               = 1'b1;
          end
        end else if (packet_position < SUM_POS) begin
          // data byte into the buffer
          buf_wr.en            = 1'b1;
          running_sum_next     = sum_add;
          packet_position_next = packet_position + 8'd1;
        end else begin
          // checksum byte
          packet_position_next = 8'd0;
          q_push               = 1'b1;
          if (rx_byte == running_sum) begin
            q_cmd.kind          = CMD_DRAIN;
            next_address_next   = next_address + 32'(PACKET_BYTES);
            expected_block_next = expected_block + 8'd1;
            drain_busy_next     = 1'b1;
          end
        end
      end
    end

    // register writes; the user must make them only while idle, the block does not enforce it
    if (cfg_wr.en) begin
      case (cfg_wr.idx)
        REG_LOAD_BASE: begin
          load_base_next    = cfg_wr.data;
          next_address_next = cfg_wr.data;
        end
        REG_TIMEOUT: begin
          timeout_ticks_next = cfg_wr.data;
        end
        default: begin
          load_base_next = load_base;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_position <= '0;
      expected_block  <= 8'd1;
      running_sum     <= '0;
      received_block  <= '0;
      next_address    <= LOAD_BASE_RESET;
      idle_ticks      <= '0;
      upload_done     <= 1'b0;
      drain_busy      <= 1'b0;
      load_base       <= LOAD_BASE_RESET;
      timeout_ticks   <= TIMEOUT_RESET;
    end else begin
      packet_position <= packet_position_next;
      expected_block  <= expected_block_next;
      running_sum     <= running_sum_next;
      received_block  <= received_block_next;
      next_address    <= next_address_next;
      idle_ticks      <= idle_ticks_next;
      upload_done     <= upload_done_next;
      drain_busy      <= drain_busy_next;
      load_base       <= load_base_next;
      timeout_ticks   <= timeout_ticks_next;
    end
  end

  a_no_fill_while_drain: assert property (@(posedge clk) disable iff (rst)
    drain_busy |-> !buf_wr.en) else $error("buffer written during drain");
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("command pushed into a full queue");
  a_silent_when_done: assert property (@(posedge clk) disable iff (rst)
    upload_done |-> !q_push && !buf_wr.en) else $error("activity after upload end");
  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    packet_position <= SUM_POS) else $error("packet position out of range");

endmodule

`default_nettype wire

// File: rtl/xmcr_back.sv
// Back of the receiver: carries out queued commands, reads the packet
// buffer and drives the result register. Depends on xmcr_pkg.
`default_nettype none

module xmcr_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_empty,
  input  wire xmcr_pkg::cmd_t                  q_head,
  output logic                                 q_pop,
  output logic [xmcr_pkg::WORD_IDX_W-1:0]      buf_raddr,
  input  wire logic [31:0]                     buf_rdata,
  output logic                                 drain_done,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 out_kind,
  output logic [7:0]                           tx_byte,
  output logic [31:0]                          write_addr,
  output logic [31:0]                          write_data,
  output logic                                 finished,
  output logic                                 last
);
  import xmcr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_ACK   = 2'd2;

  logic [1:0]            state, state_next;
  logic [WORD_IDX_W-1:0] k, k_next;
  logic [31:0]           base, base_next;
  logic                  out_valid, out_valid_next;
  logic                  out_kind_next;
  logic [7:0]            tx_byte_next;
  logic [31:0]           write_addr_next;
  logic [31:0]           write_data_next;
  logic                  finished_next;
  logic                  last_next;
  logic                  slot_free;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  // read address runs one step ahead, so buf_rdata always holds word k
  assign buf_raddr = k_next;

  // sequencer
  always_comb begin
    state_next      = state;
    k_next          = k;
    base_next       = base;
    q_pop           = 1'b0;
    drain_done      = 1'b0;
    out_valid_next  = out_valid && !pop;
    out_kind_next   = out_kind;
    tx_byte_next    = tx_byte;
    write_addr_next = write_addr;
    write_data_next = write_data;
    finished_next   = finished;
    last_next       = last;

    case (state)
      ST_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop = 1'b1;
          case (q_head.kind)
            CMD_DRAIN: begin
              state_next = ST_DRAIN;
              k_next     = '0;
              base_next  = q_head.addr;
            end
            CMD_EOT: begin
              out_valid_next  = 1'b1;
              out_kind_next   = KIND_TX;
              tx_byte_next    = CH_ACK;
              write_addr_next = '0;
              write_data_next = '0;
              finished_next   = 1'b1;
              last_next       = 1'b1;
            end
            default: begin
              out_valid_next  = 1'b1;
              out_kind_next   = KIND_TX;
              tx_byte_next    = CH_NAK;
              write_addr_next = '0;
              write_data_next = '0;
              finished_next   = 1'b0;
              last_next       = 1'b1;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_kind_next   = KIND_WRITE;
          tx_byte_next    = '0;
          write_addr_next = base + {{(30 - WORD_IDX_W){1'b0}}, k, 2'b00};
          write_data_next = buf_rdata;
          finished_next   = 1'b0;
          last_next       = 1'b0;
          if (k == WORD_LAST) begin
            state_next = ST_ACK;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      ST_ACK: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_kind_next   = KIND_TX;
          tx_byte_next    = CH_ACK;
          write_addr_next = '0;
          write_data_next = '0;
          finished_next   = 1'b0;
          last_next       = 1'b1;
          state_next      = ST_IDLE;
          drain_done      = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    k          <= k_next;
    base       <= base_next;
    out_kind   <= out_kind_next;
    tx_byte    <= tx_byte_next;
    write_addr <= write_addr_next;
    write_data <= write_data_next;
    finished   <= finished_next;
    last       <= last_next;
  end

  a_ack_after_last_word: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACK |-> k == WORD_LAST) else $error("ACK before all words");
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    drain_done |=> state == ST_IDLE) else $error("drain end without return to idle");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE && !q_empty) else $error("command taken mid-drain");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the XMODEM checksum receiver: directed rows, then
// random packets, broken headers, noise and timer ticks across register settings.
// Depends on rtl/xmcr_pkg.sv and rtl/xmodem_checksum_receiver.sv.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ITEM_TICK = 1'b0;
  localparam logic ITEM_BYTE = 1'b1;
  localparam logic [7:0] SOH = xmcr_pkg::CH_SOH;
  localparam logic [7:0] EOT = xmcr_pkg::CH_EOT;
  localparam logic [7:0] ACK = xmcr_pkg::CH_ACK;
  localparam logic [7:0] NAK = xmcr_pkg::CH_NAK;
  localparam int NBYTES = xmcr_pkg::PACKET_BYTES;
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum {LEAD_NONE, LEAD_GOOD, LEAD_BAD_SUM} lead_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic [31:0] addr;
    logic [31:0] data;
    logic        fin;
    logic        lst;
  } rx_result_t;

  // One directed row; typed rows carry their own answer (any = 0: no result)
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       typed;
    logic       any;
    logic [7:0] tx;
    logic       fin;
  } row_t;

  localparam int OPENING_ROWS = 16;
  localparam int SCRIPT_ROWS = 23;
  localparam row_t SCRIPT [0:SCRIPT_ROWS-1] = '{
    // timeout of two ticks, fresh state
    '{ITEM_TICK, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ITEM_TICK, 8'hFF, 1'b1, 1'b1, NAK,   1'b0},
    '{ITEM_BYTE, 8'h00, 1'b1, 1'b1, NAK,   1'b0},
    '{ITEM_BYTE, 8'hFF, 1'b1, 1'b1, NAK,   1'b0},
    '{ITEM_TICK, 8'h55, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ITEM_BYTE, 8'h80, 1'b1, 1'b1, NAK,   1'b0},
    // timeout mid-header keeps the position
    '{ITEM_BYTE, SOH,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ITEM_TICK, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ITEM_TICK, 8'h00, 1'b1, 1'b1, NAK,   1'b0},
    '{ITEM_BYTE, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
    '{ITEM_BYTE, 8'h00, 1'b1, 1'b1, NAK,   1'b0},
    // wrong block numbers
    '{ITEM_BYTE, SOH,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ITEM_BYTE, 8'hFF, 1'b1, 1'b1, NAK,   1'b0},
    '{ITEM_BYTE, SOH,   1'b0, 1'b0, 8'h00, 1'b0},
    '{ITEM_BYTE, 8'h00, 1'b1, 1'b1, NAK,   1'b0},
    '{ITEM_BYTE, 8'h7F, 1'b1, 1'b1, NAK,   1'b0},
    // closing rows, timeout of one tick: end of upload, then ignored items
    '{ITEM_TICK, 8'h3C, 1'b1, 1'b1, NAK,   1'b0},
    '{ITEM_BYTE, EOT,   1'b1, 1'b1, ACK,   1'b1},
    '{ITEM_TICK, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ITEM_BYTE, SOH,   1'b1, 1'b0, 8'h00, 1'b0},
    '{ITEM_BYTE, EOT,   1'b1, 1'b0, 8'h00, 1'b0},
    '{ITEM_BYTE, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{ITEM_TICK, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        cmd = ITEM_TICK;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_kind;
  logic [7:0]  tx_byte;
  logic [31:0] write_addr;
  logic [31:0] write_data;
  logic        finished;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  xmodem_checksum_receiver i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .cmd(cmd), .rx_byte(rx_byte),
    .empty(empty), .pop(pop), .out_kind(out_kind), .tx_byte(tx_byte),
    .write_addr(write_addr), .write_data(write_data), .finished(finished), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver shadow state and register copies
  logic [31:0] cfg_base = xmcr_pkg::LOAD_BASE_RESET;
  logic [31:0] cfg_timeout = xmcr_pkg::TIMEOUT_RESET;
  logic [7:0]  rx_pos = 8'd0;
  logic [7:0]  rx_block = 8'd1;
  logic [7:0]  rx_sum = 8'd0;
  logic [7:0]  rx_got_block = 8'd0;
  logic [7:0]  rx_buf [NBYTES];
  logic [31:0] rx_addr = xmcr_pkg::LOAD_BASE_RESET;
  logic [31:0] rx_idle = 32'd0;
  logic        rx_done = 1'b0;

  rx_result_t awaited[$];
  int predicted_now;
  int items_sent = 0;
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  // Work out the results of one accepted item and queue them
  task automatic predict_receiver(input logic c, input logic [7:0] b);
    logic [31:0] word;
    predicted_now = 0;
    if (rx_done) return;
    if (c == ITEM_TICK) begin
      rx_idle = rx_idle + 32'd1;
      if (rx_idle >= cfg_timeout) begin
        rx_idle = 32'd0;
        awaited.push_back('{xmcr_pkg::KIND_TX, NAK, 32'd0, 32'd0, 1'b0, 1'b1});
        predicted_now = 1;
      end
      return;
    end
    rx_idle = 32'd0;
    if (rx_pos == 8'd0) begin
      if (b == EOT) begin
        rx_done = 1'b1;
        awaited.push_back('{xmcr_pkg::KIND_TX, ACK, 32'd0, 32'd0, 1'b1, 1'b1});
        predicted_now = 1;
      end else if (b == SOH) begin
        rx_sum = b;
        rx_pos = 8'd1;
      end else begin
        awaited.push_back('{xmcr_pkg::KIND_TX, NAK, 32'd0, 32'd0, 1'b0, 1'b1});
        predicted_now = 1;
      end
    end else if (rx_pos == 8'd1 || rx_pos == 8'd2) begin
      if ((rx_pos == 8'd1 && b == rx_block) ||
          (rx_pos == 8'd2 && b == 8'(xmcr_pkg::CH_ALL - rx_got_block))) begin
        if (rx_pos == 8'd1) rx_got_block = b;
        rx_sum = rx_sum + b;
        rx_pos = rx_pos + 8'd1;
      end else begin
        rx_pos = 8'd0;
        awaited.push_back('{xmcr_pkg::KIND_TX, NAK, 32'd0, 32'd0, 1'b0, 1'b1});
        predicted_now = 1;
      end
    end else if (rx_pos < xmcr_pkg::SUM_POS) begin
      rx_buf[rx_pos - 8'd3] = b;
      rx_sum = rx_sum + b;
      rx_pos = rx_pos + 8'd1;
    end else begin
      // checksum byte closes the packet
      rx_pos = 8'd0;
      if (b != rx_sum) begin
        awaited.push_back('{xmcr_pkg::KIND_TX, NAK, 32'd0, 32'd0, 1'b0, 1'b1});
        predicted_now = 1;
        return;
      end
      for (int k = 0; k < NBYTES / 4; k++) begin
        word = {rx_buf[4*k+3], rx_buf[4*k+2], rx_buf[4*k+1], rx_buf[4*k]};
        awaited.push_back('{xmcr_pkg::KIND_WRITE, 8'h00, rx_addr + 32'(4 * k), word,
                            1'b0, 1'b0});
      end
      awaited.push_back('{xmcr_pkg::KIND_TX, ACK, 32'd0, 32'd0, 1'b0, 1'b1});
      predicted_now = NBYTES / 4 + 1;
      rx_addr = rx_addr + 32'(NBYTES);
      rx_block = rx_block + 8'd1;
    end
  endtask

  // Mostly no pause, often a short one, now and then a long one
  function automatic int pause_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // Send one item; it counts once the block has taken it
  task automatic push_item(input logic c, input logic [7:0] b);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    cmd <= c;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    predict_receiver(c, b);
  endtask

  // Wait for every awaited result, then let the block settle
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input bit wr, input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr && idx == xmcr_pkg::REG_LOAD_BASE) begin
      cfg_base = value;
      rx_addr = value;
    end else if (wr) begin
      cfg_timeout = value;
    end else begin
      compare_field(idx == xmcr_pkg::REG_LOAD_BASE ? "load_base" : "timeout_ticks",
                    idx == xmcr_pkg::REG_LOAD_BASE ? cfg_base : cfg_timeout, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_registers(input logic [31:0] base, input logic [31:0] ticks);
    reg_access(1'b1, xmcr_pkg::REG_LOAD_BASE, base);
    reg_access(1'b0, xmcr_pkg::REG_LOAD_BASE, 32'd0);
    reg_access(1'b1, xmcr_pkg::REG_TIMEOUT, ticks);
    reg_access(1'b0, xmcr_pkg::REG_TIMEOUT, 32'd0);
  endtask

  task automatic play_rows(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      push_item(SCRIPT[i].cmd, SCRIPT[i].data);
      if (SCRIPT[i].typed) begin
        repeat (predicted_now) void'(awaited.pop_back());
        if (SCRIPT[i].any)
          awaited.push_back('{xmcr_pkg::KIND_TX, SCRIPT[i].tx, 32'd0, 32'd0,
                              SCRIPT[i].fin, 1'b1});
      end
    end
  endtask

  // Whole packet for the awaited block, random data, stray ticks in between
  task automatic send_packet(input bit good_sum);
    logic [7:0] blk;
    logic [7:0] sum;
    logic [7:0] d;
    blk = rx_block;
    sum = SOH + blk + 8'(xmcr_pkg::CH_ALL - blk);
    push_item(ITEM_BYTE, SOH);
    push_item(ITEM_BYTE, blk);
    push_item(ITEM_BYTE, 8'(xmcr_pkg::CH_ALL - blk));
    for (int i = 0; i < NBYTES; i++) begin
      if ($urandom_range(0, 24) == 0) push_item(ITEM_TICK, 8'($urandom));
      d = 8'($urandom);
      sum = sum + d;
      push_item(ITEM_BYTE, d);
    end
    if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
    push_item(ITEM_BYTE, sum);
  endtask

  // One random sequence; each leaves the packet position at zero
  task automatic random_sequence();
    int r;
    logic [7:0] b;
    calm = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 50) begin
      send_packet($urandom_range(0, 3) != 0);
    end else if (r < 65) begin
      push_item(ITEM_BYTE, SOH);
      if ($urandom_range(0, 1) == 0) begin
        push_item(ITEM_BYTE, rx_block + 8'($urandom_range(1, 255)));
      end else begin
        push_item(ITEM_BYTE, rx_block);
        push_item(ITEM_BYTE, 8'(xmcr_pkg::CH_ALL - rx_block) + 8'($urandom_range(1, 255)));
      end
    end else if (r < 82) begin
      // stray bytes where a packet should start; never SOH or EOT
      repeat ($urandom_range(1, 6)) begin
        b = 8'($urandom);
        if (b == SOH || b == EOT) b = b ^ 8'h80;
        push_item(ITEM_BYTE, b);
      end
    end else begin
      repeat ($urandom_range(1, 8)) push_item(ITEM_TICK, 8'($urandom));
    end
  endtask

  task automatic run_phase(input logic [31:0] base, input logic [31:0] ticks,
                           input lead_e lead, input int budget);
    int stop;
    drain();
    set_registers(base, ticks);
    stop = items_sent + budget;
    if (lead != LEAD_NONE) send_packet(lead == LEAD_GOOD);
    while (items_sent < stop) random_sequence();
  endtask

  // Result side: random stalls on pop
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      stall_left = pause_len();
    end
  end

  // Compare each taken result with the oldest awaited one
  always @(posedge clk) begin : check_results
    rx_result_t want;
    if (!rst && pop && !empty) begin
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: no result expected, got kind %b tx %h addr %h data %h fin %b last %b",
                 $time, out_kind, tx_byte, write_addr, write_data, finished, last);
      end else begin
        want = awaited.pop_front();
        compare_field("out_kind", 32'(want.kind), 32'(out_kind));
        compare_field("tx_byte", 32'(want.tx), 32'(tx_byte));
        compare_field("write_addr", want.addr, write_addr);
        compare_field("write_data", want.data, write_data);
        compare_field("finished", 32'(want.fin), 32'(finished));
        compare_field("last", 32'(want.lst), 32'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("xmodem_checksum_receiver: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values, then the directed rows
    reg_access(1'b0, xmcr_pkg::REG_LOAD_BASE, 32'd0);
    reg_access(1'b0, xmcr_pkg::REG_TIMEOUT, 32'd0);
    set_registers(32'hFFFF_FFC0, 32'd2);
    play_rows(0, OPENING_ROWS);

    // random phases: address wrap, zero and extreme timeouts
    run_phase(32'hFFFF_FFC0, 32'hFFFF_FFFF, LEAD_GOOD, 100);
    run_phase(32'h0000_0000, 32'h0000_0000, LEAD_NONE, 30);
    run_phase($urandom, 32'd1, LEAD_BAD_SUM, 100);
    run_phase($urandom, 32'($urandom_range(2, 24)), LEAD_NONE, 30);

    // end of upload and the items after it
    calm = 1'b0;
    drain();
    set_registers(32'hFFFF_FFFF, 32'd1);
    play_rows(OPENING_ROWS, SCRIPT_ROWS);
    drain();

    if (errors == 0) begin
      $display("xmodem_checksum_receiver: match");
    end else begin
      $display("xmodem_checksum_receiver: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
